/* design/whot_pkg.sv */
`default_nettype none
package whot_pkg;

  // Counter widths of the odometry state
  localparam int COUNT_BITS = 16;
  localparam int TIME_BITS  = 32;

  // Field widths
  localparam int PWM_W     = 16;
  localparam int BAND_W    = 13;
  localparam int STEP_W    = 8;
  localparam int SPD_W     = 24;
  localparam int HEAD_W    = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int REACH_W   = COUNT_BITS + PWM_W;
  localparam int DIV_CNT_W = $clog2(SPD_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PWM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_BAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 2'd3;

  // Register reset values
  localparam logic [PWM_W-1:0]  BASE_PWM_RST     = 16'd18500;
  localparam logic [BAND_W-1:0] HEADING_BAND_RST = 13'd40;
  localparam logic [STEP_W-1:0] PWM_STEP_RST     = 8'd3;
  localparam logic [SPD_W-1:0]  SPEED_SCALE_RST  = 24'd10000000;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [PWM_W-1:0]     PWM_MAX   = {PWM_W{1'b1}};
  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } whot_div_stat_t;

  function automatic logic [TIME_BITS-1:0] sat_inc_time(input logic [TIME_BITS-1:0] t);
    return (t == TIME_MAX) ? t : t + 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc_count(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Count has reached target, compared at a common width
  function automatic logic reaches(input logic [COUNT_BITS-1:0] c,
                                   input logic [PWM_W-1:0] tgt);
    return REACH_W'(c) >= REACH_W'(tgt);
  endfunction

  // Pulse count clipped to the output field
  function automatic logic [PWM_W-1:0] pulse_sat(input logic [COUNT_BITS-1:0] c);
    logic [REACH_W-1:0] w;
    w = REACH_W'(c);
    return (w > REACH_W'(PWM_MAX)) ? PWM_MAX : w[PWM_W-1:0];
  endfunction

  // PWM plus step, saturating
  function automatic logic [PWM_W-1:0] pwm_add(input logic [PWM_W-1:0] p,
                                               input logic [STEP_W-1:0] s);
    logic [PWM_W:0] sum;
    sum = {1'b0, p} + (PWM_W+1)'(s);
    return sum[PWM_W] ? PWM_MAX : sum[PWM_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/whot_if.sv */
`default_nettype none
// Sample channel: one start or tick item
interface whot_in_if
  import whot_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [PWM_W-1:0]         target_pulses;
  logic                     move_dir;
  logic signed [HEAD_W-1:0] heading;
  logic                     left_level;
  logic                     right_level;

  modport source (output valid, command, target_pulses, move_dir, heading,
                  left_level, right_level, input ready);
  modport sink   (input valid, command, target_pulses, move_dir, heading,
                  left_level, right_level, output ready);
endinterface

// Report channel: one result item per sample item
interface whot_out_if
  import whot_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PWM_W-1:0] left_drive;
  logic [PWM_W-1:0] right_drive;
  logic [SPD_W-1:0] left_speed;
  logic [SPD_W-1:0] right_speed;
  logic [PWM_W-1:0] left_pulses;
  logic [PWM_W-1:0] right_pulses;
  logic             drive_dir;
  logic             done_res;

  modport source (output valid, left_drive, right_drive, left_speed, right_speed,
                  left_pulses, right_pulses, drive_dir, done_res, input ready);
  modport sink   (input valid, left_drive, right_drive, left_speed, right_speed,
                  left_pulses, right_pulses, drive_dir, done_res, output ready);
endinterface
`default_nettype wire

/* design/whot_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// The dividend is as wide as the quotient, so the quotient never overflows.
module whot_div
  import whot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [SPD_W-1:0]     dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output whot_div_stat_t       stat,
  output logic [SPD_W-1:0]     quotient
);

  logic [TIME_BITS-1:0] rem;
  logic [SPD_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 fits;

  // One trial subtraction
  always_comb begin
    trial = {rem, quo[SPD_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SPD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo <= {quo[SPD_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
`default_nettype wire

/* design/wheel_odometry_heading_trim_core.sv */
`default_nettype none
// Two-wheel odometry with heading trim.
// Channels: sample (sink) carries start items (command 0) and one-microsecond
// tick items (command 1); report (source) returns exactly one result item for
// every sample item, in order. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data), to be written only while the block is idle;
// the user must keep to this, the block itself does not enforce it. A start
// item, an idle tick or a tick without an encoder pulse gives its result in
// the cycle after acceptance. Each encoder pulse needs a speed quotient from
// the single shared restoring divider (24 quotient bits plus launch and
// hand-back), so a tick waits for none, one or two divisions, one per wheel.
// One item is handled at a time: sample.ready is high only when the divider
// sequencer is idle and the report register is empty or being taken.
// When the receiver stalls, the result holds in the report register and the
// block takes no further sample item.
// Reset (rst, synchronous) restores the register defaults, stops any move,
// clears counters, speeds and drives, and empties the report register.
module wheel_odometry_heading_trim_core
  import whot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  whot_in_if.sink              sample,
  whot_out_if.source           report
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV_L = 2'd1;
  localparam logic [1:0] S_DIV_R = 2'd2;

  // Configuration registers
  logic [PWM_W-1:0]  base_pwm;
  logic [BAND_W-1:0] heading_band;
  logic [STEP_W-1:0] pwm_step;
  logic [SPD_W-1:0]  speed_scale;

  // Move state
  logic                     moving, moving_next;
  logic [PWM_W-1:0]         target, target_next;
  logic signed [HEAD_W-1:0] ref_heading, ref_heading_next;
  logic                     dir_reg, dir_reg_next;
  logic                     left_armed, left_armed_next;
  logic                     right_armed, right_armed_next;
  logic [COUNT_BITS-1:0]    left_count, left_count_next;
  logic [COUNT_BITS-1:0]    right_count, right_count_next;
  logic [TIME_BITS-1:0]     left_ticks, left_ticks_next;
  logic [TIME_BITS-1:0]     right_ticks, right_ticks_next;
  logic [PWM_W-1:0]         left_pwm, left_pwm_next;
  logic [PWM_W-1:0]         right_pwm, right_pwm_next;
  logic [PWM_W-1:0]         left_out, left_out_next;
  logic [PWM_W-1:0]         right_out, right_out_next;
  logic [SPD_W-1:0]         left_spd;
  logic [SPD_W-1:0]         right_spd;
  logic                     done_reg, done_next;

  // Sequencer and divider operands
  logic [1:0]           state;
  logic                 out_valid;
  logic                 pend_r;
  logic                 div_go;
  logic [TIME_BITS-1:0] left_div, right_div;
  whot_div_stat_t       div_stat;
  logic [SPD_W-1:0]     div_quo;

  logic                     in_acc;
  logic                     pulse_l, pulse_r;
  logic [TIME_BITS-1:0]     lt_inc, rt_inc;
  logic [COUNT_BITS-1:0]    lc_inc, rc_inc;
  logic signed [HEAD_W+1:0] diff;
  logic signed [HEAD_W+1:0] band_s;
  logic                     below, above;

  assign sample.ready = (state == S_IDLE) && (!out_valid || report.ready);
  assign in_acc       = sample.valid && sample.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_pwm     <= BASE_PWM_RST;
      heading_band <= HEADING_BAND_RST;
      pwm_step     <= PWM_STEP_RST;
      speed_scale  <= SPEED_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_PWM:     base_pwm     <= cfg_data[PWM_W-1:0];
        REG_HEADING_BAND: heading_band <= cfg_data[BAND_W-1:0];
        REG_PWM_STEP:     pwm_step     <= cfg_data[STEP_W-1:0];
        REG_SPEED_SCALE:  speed_scale  <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Heading error against the band
  always_comb begin
    diff   = (HEAD_W+2)'(sample.heading) - (HEAD_W+2)'(ref_heading);
    band_s = $signed((HEAD_W+2)'(heading_band));
    below  = diff < -band_s;
    above  = diff > band_s;
    lt_inc = sat_inc_time(left_ticks);
    rt_inc = sat_inc_time(right_ticks);
    lc_inc = sat_inc_count(left_count);
    rc_inc = sat_inc_count(right_count);
  end

  // Next state for one accepted item
  always_comb begin
    moving_next      = moving;
    target_next      = target;
    ref_heading_next = ref_heading;
    dir_reg_next     = dir_reg;
    left_armed_next  = left_armed;
    right_armed_next = right_armed;
    left_count_next  = left_count;
    right_count_next = right_count;
    left_ticks_next  = left_ticks;
    right_ticks_next = right_ticks;
    left_pwm_next    = left_pwm;
    right_pwm_next   = right_pwm;
    left_out_next    = left_out;
    right_out_next   = right_out;
    done_next        = done_reg;
    pulse_l          = 1'b0;
    pulse_r          = 1'b0;
    if (in_acc) begin
      done_next = 1'b0;
      if (sample.command == CMD_START) begin
        target_next      = sample.target_pulses;
        dir_reg_next     = sample.move_dir;
        ref_heading_next = sample.heading;
        left_pwm_next    = base_pwm;
        right_pwm_next   = base_pwm;
        left_out_next    = base_pwm;
        right_out_next   = base_pwm;
        left_count_next  = '0;
        right_count_next = '0;
        left_ticks_next  = '0;
        right_ticks_next = '0;
        left_armed_next  = 1'b0;
        right_armed_next = 1'b0;
        moving_next      = 1'b1;
      end else if (moving) begin
        // heading trim
        if (below) begin
          left_pwm_next = pwm_add(left_pwm, pwm_step);
          left_out_next = left_pwm_next;
        end
        if (above) begin
          right_pwm_next = pwm_add(right_pwm, pwm_step);
          right_out_next = right_pwm_next;
        end
        // left encoder: high then low is one pulse
        left_ticks_next = lt_inc;
        if (sample.left_level) begin
          left_armed_next = 1'b1;
        end else if (left_armed) begin
          left_armed_next = 1'b0;
          left_count_next = lc_inc;
          if (reaches(lc_inc, target)) left_out_next = '0;
          left_ticks_next = '0;
          pulse_l         = 1'b1;
        end
        // right encoder
        right_ticks_next = rt_inc;
        if (sample.right_level) begin
          right_armed_next = 1'b1;
        end else if (right_armed) begin
          right_armed_next = 1'b0;
          right_count_next = rc_inc;
          if (reaches(rc_inc, target)) right_out_next = '0;
          right_ticks_next = '0;
          pulse_r          = 1'b1;
        end
        // both wheels at target ends the move
        if (reaches(left_count_next, target) && reaches(right_count_next, target)) begin
          left_pwm_next  = base_pwm;
          right_pwm_next = base_pwm;
          moving_next    = 1'b0;
          done_next      = 1'b1;
        end
      end
    end
  end

  // Move state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      moving      <= 1'b0;
      target      <= '0;
      ref_heading <= '0;
      dir_reg     <= 1'b0;
      left_armed  <= 1'b0;
      right_armed <= 1'b0;
      left_count  <= '0;
      right_count <= '0;
      left_ticks  <= '0;
      right_ticks <= '0;
      left_pwm    <= BASE_PWM_RST;
      right_pwm   <= BASE_PWM_RST;
      left_out    <= '0;
      right_out   <= '0;
      done_reg    <= 1'b0;
    end else begin
      moving      <= moving_next;
      target      <= target_next;
      ref_heading <= ref_heading_next;
      dir_reg     <= dir_reg_next;
      left_armed  <= left_armed_next;
      right_armed <= right_armed_next;
      left_count  <= left_count_next;
      right_count <= right_count_next;
      left_ticks  <= left_ticks_next;
      right_ticks <= right_ticks_next;
      left_pwm    <= left_pwm_next;
      right_pwm   <= right_pwm_next;
      left_out    <= left_out_next;
      right_out   <= right_out_next;
      done_reg    <= done_next;
    end
  end

  // Divisors: ticks up to and including the pulse tick
  always_ff @(posedge clk) begin
    if (pulse_l) left_div <= lt_inc;
    if (pulse_r) right_div <= rt_inc;
  end

  // Speed registers, loaded from the shared divider
  always_ff @(posedge clk) begin
    if (rst) begin
      left_spd  <= '0;
      right_spd <= '0;
    end else if (div_stat.done) begin
      if (state == S_DIV_L) left_spd <= div_quo;
      if (state == S_DIV_R) right_spd <= div_quo;
    end
  end

  // Sequencer: left division, then right, then report
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend_r    <= 1'b0;
      div_go    <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (report.valid && report.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (pulse_l) begin
              state  <= S_DIV_L;
              div_go <= 1'b1;
              pend_r <= pulse_r;
            end else if (pulse_r) begin
              state  <= S_DIV_R;
              div_go <= 1'b1;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_DIV_L: begin
          if (div_stat.done) begin
            if (pend_r) begin
              state  <= S_DIV_R;
              div_go <= 1'b1;
            end else begin
              state     <= S_IDLE;
              out_valid <= 1'b1;
            end
          end
        end
        S_DIV_R: begin
          if (div_stat.done) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  whot_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (speed_scale),
    .divisor  ((state == S_DIV_R) ? right_div : left_div),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Report register is the state itself
  assign report.valid        = out_valid;
  assign report.left_drive   = left_out;
  assign report.right_drive  = right_out;
  assign report.left_speed   = left_spd;
  assign report.right_speed  = right_spd;
  assign report.left_pulses  = pulse_sat(left_count);
  assign report.right_pulses = pulse_sat(right_count);
  assign report.drive_dir    = dir_reg;
  assign report.done_res     = done_reg;

  // Checks
  a_no_report_while_dividing: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("report valid while a division is pending");

  a_div_idle_when_seq_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy with sequencer idle");

  a_start_reports_next: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (sample.command == CMD_START)) |=> (out_valid && moving && !done_reg))
    else $error("start item not reported in the next cycle");

  a_done_ends_move: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_reg) |-> !moving)
    else $error("done reported while still moving");

endmodule
`default_nettype wire
